// ===== design/mdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types and constants for the magnitude to dB colour pixel block.
// ----------------------------------------------------------------------------
package mdb_pkg;

    localparam logic [1:0] REG_LOW_DB  = 2'd0;
    localparam logic [1:0] REG_HIGH_DB = 2'd1;
    localparam logic [1:0] REG_ENTRIES = 2'd2;

    localparam int LOG_STEPS = 24;
    localparam logic [63:0] EPS_SCALED = 64'd1844674407;
    localparam logic signed [27:0] DB_PER_OCTAVE_Q24 = 28'sd101008905;
    localparam logic signed [8:0] DB_FLOOR = -9'sd180;
    localparam logic signed [8:0] DB_CEIL = 9'sd150;

    // One item in the queue between the front and the back.
    typedef struct packed {
        logic        cmd;
        logic [31:0] magnitude;
        logic        end_of_strip;
        logic [7:0]  entry_index;
        logic [31:0] entry_colour;
    } item_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic signed [8:0] low_db;
        logic signed [8:0] high_db;
        logic [8:0]        table_entries;
    } cfg_t;

endpackage

// ===== design/mdb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_front
// Input queue that decouples the input side from the compute pipeline.
// ----------------------------------------------------------------------------
module mdb_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  mdb_pkg::item_t in_item,
    output logic           item_valid,
    input  logic           item_take,
    output mdb_pkg::item_t item
);

    mdb_pkg::item_t q_reg [4];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [2:0] cnt_reg;
    logic do_push;
    logic do_pop;

    assign full = (cnt_reg == 3'd4);
    assign do_push = push && !full;
    assign item_valid = (cnt_reg != 3'd0);
    assign do_pop = item_valid && item_take;
    assign item = q_reg[rd_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= in_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, do_push} - {2'd0, do_pop};
        end
    end

endmodule

// ===== design/mdb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_back
// Pipelined log2, dB scaling, clamping, index division and table lookup.
// ----------------------------------------------------------------------------
module mdb_back
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  mdb_pkg::item_t        in_item,
    input  mdb_pkg::cfg_t         cfg,
    input  logic                  advance,
    output logic                  out_valid,
    output logic [31:0]           pixel_colour,
    output logic [7:0]            colour_index,
    output logic signed [16:0]    level_db,
    output logic                  strip_end
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CAP = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int NS = mdb_pkg::LOG_STEPS;
    localparam int DS = 9;
    // A table write reaches the table on the same edge on which a pixel
    // that entered with it would read the table.
    localparam int WD = NS + DS + 5;

    logic [31:0] colour_table [TABLE_DEPTH];

    // Stage A: square.
    logic        a_v_reg;
    logic [63:0] a_x_reg;
    logic        a_e_reg;
    // Log iterations; entry 0 holds the normalized mantissa.
    logic        l_v_reg [NS+1];
    logic [32:0] l_m_reg [NS+1];
    logic [23:0] l_f_reg [NS+1];
    logic signed [7:0] l_p_reg [NS+1];
    logic        l_e_reg [NS+1];
    // Stage C: scale multiply.
    logic        c_v_reg;
    logic signed [63:0] c_prod_reg;
    logic        c_e_reg;
    // Stage D: clamp.
    logic        d_v_reg;
    logic signed [16:0] d_db_reg;
    logic        d_e_reg;
    logic        d_ok_reg;
    logic [8:0]  d_em1_reg;
    // Restoring division, DS bits of quotient; entry 0 holds the operands.
    logic        q_v_reg  [DS+1];
    logic [25:0] q_r_reg  [DS+1];
    logic [8:0]  q_q_reg  [DS+1];
    logic [16:0] q_d_reg  [DS+1];
    logic signed [16:0] q_db_reg [DS+1];
    logic        q_e_reg  [DS+1];
    logic        q_ok_reg [DS+1];
    logic [8:0]  q_em1_reg [DS+1];
    // Stage F: index and read.
    logic        f_v_reg;
    logic [7:0]  f_idx_reg;
    logic signed [16:0] f_db_reg;
    logic        f_e_reg;
    logic [31:0] f_col_reg;
    // Table write delay line.
    logic          w_v_reg   [WD];
    logic [AW-1:0] w_idx_reg [WD];
    logic [31:0]   w_col_reg [WD];

    logic [63:0] y_c;
    logic [6:0]  p_c;
    logic [32:0] mant_c;
    logic signed [8:0] lo_c;
    logic signed [8:0] hi_c;
    logic signed [16:0] lvl_c;
    logic signed [16:0] db_c;
    logic [8:0]  en_c;
    logic [8:0]  idx_c;
    logic [65:0] sq_c [NS];
    logic [32:0] nm_c [NS];
    logic        bit_c [NS];
    logic [26:0] tr_c [DS];

    // Table writes land at the read stage, so pixels see them in input order.
    always_ff @(posedge clk)
    begin
        if (advance && w_v_reg[WD-1])
        begin
            colour_table[w_idx_reg[WD-1]] <= w_col_reg[WD-1];
        end
    end

    // Normalization of the padded square.
    always_comb
    begin
        y_c = (a_x_reg[63:32] == 32'd0)
            ? ({a_x_reg[31:0], 32'd0} + mdb_pkg::EPS_SCALED) : a_x_reg;
        p_c = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (y_c[i])
            begin
                p_c = 7'(i);
            end
        end
        mant_c = 33'((y_c << (7'd63 - p_c)) >> 32);
    end

    // One square-and-compare step per stage.
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            sq_c[i] = 66'(({33'd0, l_m_reg[i]} * {33'd0, l_m_reg[i]}) >> 31);
            bit_c[i] = sq_c[i][32];
            nm_c[i] = bit_c[i] ? sq_c[i][33:1] : sq_c[i][32:0];
        end
    end

    // Level in Q8.8 with round half up.
    always_comb
    begin
        lvl_c = 17'(c_prod_reg >>> 40);
        lo_c = (cfg.low_db > mdb_pkg::DB_FLOOR) ? cfg.low_db : mdb_pkg::DB_FLOOR;
        hi_c = (cfg.high_db < mdb_pkg::DB_CEIL) ? cfg.high_db : mdb_pkg::DB_CEIL;
        db_c = lvl_c;
        if (db_c > signed'({hi_c, 8'd0}))
        begin
            db_c = signed'({hi_c, 8'd0});
        end
        if (db_c < signed'({lo_c, 8'd0}))
        begin
            db_c = signed'({lo_c, 8'd0});
        end
        en_c = cfg.table_entries;
        if (en_c < 9'd1)
        begin
            en_c = 9'd1;
        end
        if (en_c > 9'(CAP))
        begin
            en_c = 9'(CAP);
        end
    end

    // Division trial subtracts.
    always_comb
    begin
        for (int i = 0; i < DS; i++)
        begin
            tr_c[i] = {1'b0, q_r_reg[i]}
                - ({10'd0, q_d_reg[i]} << (DS - 1 - i));
        end
        idx_c = (q_q_reg[DS] > q_em1_reg[DS]) ? q_em1_reg[DS] : q_q_reg[DS];
        if (!q_ok_reg[DS])
        begin
            idx_c = 9'd0;
        end
    end

    // Payload pipeline.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_x_reg <= {32'd0, in_item.magnitude} * {32'd0, in_item.magnitude};
            a_e_reg <= in_item.end_of_strip;
            l_m_reg[0] <= mant_c;
            l_f_reg[0] <= '0;
            l_p_reg[0] <= (a_x_reg[63:32] == 32'd0)
                ? 8'(signed'({1'b0, p_c}) - 8'sd64)
                : 8'(signed'({1'b0, p_c}) - 8'sd32);
            l_e_reg[0] <= a_e_reg;
            for (int i = 0; i < NS; i++)
            begin
                l_m_reg[i+1] <= nm_c[i];
                l_f_reg[i+1] <= {l_f_reg[i][22:0], bit_c[i]};
                l_p_reg[i+1] <= l_p_reg[i];
                l_e_reg[i+1] <= l_e_reg[i];
            end
            c_prod_reg <= 64'(signed'({l_p_reg[NS], l_f_reg[NS]}))
                * 64'(mdb_pkg::DB_PER_OCTAVE_Q24) + 64'sd549755813888;
            c_e_reg <= l_e_reg[NS];
            d_db_reg <= db_c;
            d_e_reg <= c_e_reg;
            d_ok_reg <= (lo_c < hi_c);
            d_em1_reg <= en_c - 9'd1;
            q_db_reg[0] <= d_db_reg;
            q_e_reg[0] <= d_e_reg;
            q_ok_reg[0] <= d_ok_reg;
            q_em1_reg[0] <= d_em1_reg;
            q_q_reg[0] <= '0;
            q_r_reg[0] <= {17'd0, d_em1_reg}
                * {9'd0, 17'(d_db_reg - signed'({lo_c, 8'd0}))};
            q_d_reg[0] <= {9'(17'(hi_c) - 17'(lo_c)), 8'd0};
            for (int i = 0; i < DS; i++)
            begin
                q_r_reg[i+1] <= tr_c[i][26] ? q_r_reg[i] : tr_c[i][25:0];
                q_q_reg[i+1] <= {q_q_reg[i][7:0], !tr_c[i][26]};
                q_d_reg[i+1] <= q_d_reg[i];
                q_db_reg[i+1] <= q_db_reg[i];
                q_e_reg[i+1] <= q_e_reg[i];
                q_ok_reg[i+1] <= q_ok_reg[i];
                q_em1_reg[i+1] <= q_em1_reg[i];
            end
            f_idx_reg <= idx_c[7:0];
            f_db_reg <= q_db_reg[DS];
            f_e_reg <= q_e_reg[DS];
            f_col_reg <= colour_table[AW'(idx_c)];
            w_idx_reg[0] <= AW'(in_item.entry_index);
            w_col_reg[0] <= in_item.entry_colour;
            for (int i = 0; i < WD - 1; i++)
            begin
                w_idx_reg[i+1] <= w_idx_reg[i];
                w_col_reg[i+1] <= w_col_reg[i];
            end
        end
    end

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            for (int i = 0; i <= NS; i++)
            begin
                l_v_reg[i] <= 1'b0;
            end
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            for (int i = 0; i <= DS; i++)
            begin
                q_v_reg[i] <= 1'b0;
            end
            f_v_reg <= 1'b0;
            for (int i = 0; i < WD; i++)
            begin
                w_v_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            a_v_reg <= in_valid && !in_item.cmd;
            l_v_reg[0] <= a_v_reg;
            for (int i = 0; i < NS; i++)
            begin
                l_v_reg[i+1] <= l_v_reg[i];
            end
            c_v_reg <= l_v_reg[NS];
            d_v_reg <= c_v_reg;
            q_v_reg[0] <= d_v_reg;
            for (int i = 0; i < DS; i++)
            begin
                q_v_reg[i+1] <= q_v_reg[i];
            end
            f_v_reg <= q_v_reg[DS];
            w_v_reg[0] <= in_valid && in_item.cmd
                && ({24'd0, in_item.entry_index} < 32'(TABLE_DEPTH));
            for (int i = 0; i < WD - 1; i++)
            begin
                w_v_reg[i+1] <= w_v_reg[i];
            end
        end
    end

    assign out_valid = f_v_reg;
    assign pixel_colour = f_col_reg;
    assign colour_index = f_idx_reg;
    assign level_db = f_db_reg;
    assign strip_end = f_e_reg;

endmodule

// ===== design/magnitude_to_db_colour_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnitude_to_db_colour_pixel
// Spectrogram magnitude to dB level, colour index and ARGB pixel.
// ----------------------------------------------------------------------------
// One item is taken per clock while the pipeline advances. A magnitude passes
// a fixed pipeline of 39 stages (one square-and-compare step of the log2 per
// stage, one quotient bit of the index division per stage) and then the
// output register that drives the result ports. A table write travels down a
// delay line that stalls with the pipeline and lands at the table read stage,
// so each pixel sees exactly the writes sent before it. The pipeline advances
// whenever its last stage is empty or the output register can take it, so a
// full output stalls only the pipeline; the input queue keeps accepting until
// it holds four items.
module magnitude_to_db_colour_pixel
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               cmd,
    input  logic [31:0]        magnitude,
    input  logic               end_of_strip,
    input  logic [7:0]         entry_index,
    input  logic [31:0]        entry_colour,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        pixel_colour,
    output logic [7:0]         colour_index,
    output logic signed [16:0] level_db,
    output logic               strip_end,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    mdb_pkg::item_t in_item;
    mdb_pkg::item_t item;
    mdb_pkg::cfg_t  cfg_reg;
    logic item_valid;
    logic advance;
    logic p_valid;
    logic [31:0] p_col;
    logic [7:0]  p_idx;
    logic signed [16:0] p_db;
    logic p_end;
    logic o_valid_reg;

    assign in_item = '{cmd: cmd, magnitude: magnitude, end_of_strip: end_of_strip,
                       entry_index: entry_index, entry_colour: entry_colour};
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_db <= -9'sd70;
            cfg_reg.high_db <= 9'sd40;
            cfg_reg.table_entries <= 9'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mdb_pkg::REG_LOW_DB:  cfg_reg.low_db <= cfg_data;
                mdb_pkg::REG_HIGH_DB: cfg_reg.high_db <= cfg_data;
                mdb_pkg::REG_ENTRIES: cfg_reg.table_entries <= cfg_data;
                default: ;
            endcase
        end
    end

    mdb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (advance),
        .item       (item)
    );

    // The pipeline moves unless a finished pixel is blocked at the output.
    assign advance = !(p_valid && o_valid_reg && !pop);

    mdb_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (item_valid),
        .in_item      (item),
        .cfg          (cfg_reg),
        .advance      (advance),
        .out_valid    (p_valid),
        .pixel_colour (p_col),
        .colour_index (p_idx),
        .level_db     (p_db),
        .strip_end    (p_end)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (p_valid)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p_valid)
        begin
            pixel_colour <= p_col;
            colour_index <= p_idx;
            level_db <= p_db;
            strip_end <= p_end;
        end
    end

    assign empty = !o_valid_reg;

endmodule
